@@ hw/rtl/kwm_pkg.sv @@
// Shared types and constants of the k-way sorted merge block.
// No dependencies; every other file of the block refers to it by scoped names.

package kwm_pkg;

   localparam int VALUE_W  = 16;
   localparam int SOURCE_W = 3;
   localparam int INDEX_W  = 3;

   // Item kinds on the request channel
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_MERGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_POP_RD,
      ST_POP_CMP
   } kwm_state_type;

   typedef struct packed {
      logic                       kind;
      logic [INDEX_W-1:0]         list_index;
      logic signed [VALUE_W-1:0]  value;
   } kwm_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  merged_value;
      logic [SOURCE_W-1:0]        source_list;
      logic                       last;
      logic                       dropped_any;
   } kwm_result_type;

endpackage

@@ hw/rtl/kwm_if.sv @@
// Valid/ready channel interfaces of the k-way sorted merge block.
// Depends on kwm_pkg for the field widths.

interface kwm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [kwm_pkg::INDEX_W-1:0]         list_index;
   logic signed [kwm_pkg::VALUE_W-1:0]  value;

   modport source (output valid, kind, list_index, value, input ready);
   modport sink   (input valid, kind, list_index, value, output ready);
endinterface

interface kwm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kwm_pkg::VALUE_W-1:0]  merged_value;
   logic [kwm_pkg::SOURCE_W-1:0]        source_list;
   logic                                last;
   logic                                dropped_any;

   modport source (output valid, merged_value, source_list, last, dropped_any, input ready);
   modport sink   (input valid, merged_value, source_list, last, dropped_any, output ready);
endinterface

@@ hw/rtl/k_way_sorted_merge.sv @@
// k_way_sorted_merge: a load beat appends a signed 16-bit value to list list_index (ignored when
// the index is not below NUM_LISTS; dropped, with the sticky dropped_any flag set, when that list
// already holds LIST_DEPTH elements). A merge beat emits every stored element:
// each round scans the lists for the least head, then walks the lists in index order popping each
// run of heads equal to it, one result beat per element, with last on the final one; afterwards
// all lists are empty. A merge with nothing stored gives no beat. The block accepts nothing while
// a merge runs. A scan visit to an empty list reads nothing; any other visit is a store read,
// then the shared compare, as the element store has a single read port. A result-side stall
// holds the merge. Results pass through an output register, so loads may proceed while the
// last result still waits. Depends on kwm_pkg, kwm_if, kwm_store and kwm_seq.

module k_way_sorted_merge #(
   parameter int NUM_LISTS  = 8,
   parameter int LIST_DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   kwm_req_if.sink      req,
   kwm_rsp_if.source    rsp
);

   localparam int CAP    = NUM_LISTS * LIST_DEPTH;
   localparam int ADDR_W = $clog2(CAP);

   kwm_pkg::kwm_item_type   req_item;
   kwm_pkg::kwm_result_type emit_data;
   kwm_pkg::kwm_result_type rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    emit_valid;
   logic                    emit_ready;

   logic                                mem_wr_en;
   logic [ADDR_W-1:0]                   mem_wr_addr;
   logic signed [kwm_pkg::VALUE_W-1:0]  mem_wr_data;
   logic                                mem_rd_en;
   logic [ADDR_W-1:0]                   mem_rd_addr;
   logic signed [kwm_pkg::VALUE_W-1:0]  mem_rd_data;

   assign req_item.kind       = req.kind;
   assign req_item.list_index = req.list_index;
   assign req_item.value      = req.value;

   kwm_seq #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .in_item     (req_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit_data   (emit_data)
   );

   kwm_store #(
      .DEPTH  (CAP),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: take a new beat when empty or when the held beat leaves
   assign emit_ready = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ready) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.merged_value = rsp_data_ff.merged_value;
   assign rsp.source_list  = rsp_data_ff.source_list;
   assign rsp.last         = rsp_data_ff.last;
   assign rsp.dropped_any  = rsp_data_ff.dropped_any;

endmodule

@@ hw/rtl/kwm_store.sv @@
// Element store: single write port, single read port with registered read data.
// Depends on kwm_pkg for the element width.

module kwm_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic signed [kwm_pkg::VALUE_W-1:0]  wr_data,
   input  logic                                rd_en,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic signed [kwm_pkg::VALUE_W-1:0]  rd_data
);

   logic signed [kwm_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [kwm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kwm_seq.sv @@
// Merge sequencer: per-list fill and head counters, shared head compare, load path.
// Depends on kwm_pkg; drives the ports of kwm_store.

module kwm_seq #(
   parameter int NUM_LISTS  = 8,
   parameter int LIST_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  kwm_pkg::kwm_item_type               in_item,
   output logic                                mem_wr_en,
   output logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0] mem_wr_addr,
   output logic signed [kwm_pkg::VALUE_W-1:0]  mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0] mem_rd_addr,
   input  logic signed [kwm_pkg::VALUE_W-1:0]  mem_rd_data,
   output logic                                emit_valid,
   input  logic                                emit_ready,
   output kwm_pkg::kwm_result_type             emit_data
);

   localparam int CAP    = NUM_LISTS * LIST_DEPTH;
   localparam int LIST_W = $clog2(NUM_LISTS);
   localparam int ADDR_W = $clog2(CAP);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int TOT_W  = $clog2(CAP + 1);

   kwm_pkg::kwm_state_type state_ff, state_in;

   logic [CNT_W-1:0]  fill_ff [NUM_LISTS];
   logic [CNT_W-1:0]  fill_in [NUM_LISTS];
   logic [CNT_W-1:0]  head_ff [NUM_LISTS];
   logic [CNT_W-1:0]  head_in [NUM_LISTS];
   logic [TOT_W-1:0]  remaining_ff, remaining_in;
   logic [LIST_W-1:0] cur_ff, cur_in;
   logic              found_ff, found_in;
   logic              overflow_ff, overflow_in;
   logic signed [kwm_pkg::VALUE_W-1:0] least_ff, least_in;

   logic [LIST_W-1:0] sel_idx;
   logic [CNT_W-1:0]  fill_sel;
   logic [CNT_W-1:0]  head_cur;
   logic [ADDR_W-1:0] base_addr;
   logic              in_range;
   logic              cur_live;
   logic              cur_last;
   logic              head_match;

   // Load path addresses the named list; the merge scan addresses the current list
   assign sel_idx    = (state_ff == kwm_pkg::ST_IDLE) ? LIST_W'(in_item.list_index) : cur_ff;
   assign fill_sel   = fill_ff[sel_idx];
   assign head_cur   = head_ff[cur_ff];
   assign base_addr  = ADDR_W'(sel_idx * LIST_DEPTH);
   assign in_range   = {29'd0, in_item.list_index} < 32'(NUM_LISTS);
   assign cur_live   = head_cur < fill_sel;
   assign cur_last   = cur_ff == LIST_W'(NUM_LISTS - 1);
   assign head_match = mem_rd_data == least_ff;

   assign in_ready    = state_ff == kwm_pkg::ST_IDLE;
   assign mem_wr_addr = base_addr + ADDR_W'(fill_sel);
   assign mem_rd_addr = base_addr + ADDR_W'(head_cur);
   assign mem_wr_data = in_item.value;

   assign emit_data.merged_value = mem_rd_data;
   assign emit_data.source_list  = kwm_pkg::SOURCE_W'(cur_ff);
   assign emit_data.last         = remaining_ff == TOT_W'(1);
   assign emit_data.dropped_any  = overflow_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (in_valid && in_item.kind == kwm_pkg::KIND_MERGE && remaining_ff != '0) begin
               state_in = kwm_pkg::ST_FIND_RD;
            end
         end
         kwm_pkg::ST_FIND_RD: begin
            if (cur_live) begin
               state_in = kwm_pkg::ST_FIND_CMP;
            end else if (cur_last) begin
               state_in = kwm_pkg::ST_POP_RD;
            end
         end
         kwm_pkg::ST_FIND_CMP: begin
            state_in = cur_last ? kwm_pkg::ST_POP_RD : kwm_pkg::ST_FIND_RD;
         end
         kwm_pkg::ST_POP_RD: begin
            if (cur_live) begin
               state_in = kwm_pkg::ST_POP_CMP;
            end else if (cur_last) begin
               state_in = kwm_pkg::ST_FIND_RD;
            end
         end
         kwm_pkg::ST_POP_CMP: begin
            if (head_match) begin
               if (emit_ready) begin
                  state_in = (remaining_ff == TOT_W'(1)) ? kwm_pkg::ST_IDLE
                                                         : kwm_pkg::ST_POP_RD;
               end
            end else begin
               state_in = cur_last ? kwm_pkg::ST_FIND_RD : kwm_pkg::ST_POP_RD;
            end
         end
         default: state_in = kwm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      fill_in      = fill_ff;
      head_in      = head_ff;
      remaining_in = remaining_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      least_in     = least_ff;
      overflow_in  = overflow_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      emit_valid   = 1'b0;
      unique case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (in_valid) begin
               if (in_item.kind == kwm_pkg::KIND_LOAD) begin
                  if (in_range) begin
                     if (fill_sel == CNT_W'(LIST_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        mem_wr_en         = 1'b1;
                        fill_in[sel_idx]  = fill_sel + CNT_W'(1);
                        remaining_in      = remaining_ff + TOT_W'(1);
                     end
                  end
               end else begin
                  cur_in   = '0;
                  found_in = 1'b0;
               end
            end
         end
         kwm_pkg::ST_FIND_RD: begin
            if (cur_live) begin
               mem_rd_en = 1'b1;
            end else begin
               cur_in = cur_last ? '0 : cur_ff + LIST_W'(1);
            end
         end
         kwm_pkg::ST_FIND_CMP: begin
            if (!found_ff || mem_rd_data < least_ff) begin
               least_in = mem_rd_data;
               found_in = 1'b1;
            end
            cur_in = cur_last ? '0 : cur_ff + LIST_W'(1);
         end
         kwm_pkg::ST_POP_RD: begin
            if (cur_live) begin
               mem_rd_en = 1'b1;
            end else if (cur_last) begin
               cur_in   = '0;
               found_in = 1'b0;
            end else begin
               cur_in = cur_ff + LIST_W'(1);
            end
         end
         kwm_pkg::ST_POP_CMP: begin
            if (head_match) begin
               emit_valid = 1'b1;
               if (emit_ready) begin
                  head_in[cur_ff] = head_cur + CNT_W'(1);
                  remaining_in    = remaining_ff - TOT_W'(1);
                  if (remaining_ff == TOT_W'(1)) begin
                     // Final beat: empty every list
                     for (int i = 0; i < NUM_LISTS; i++) begin
                        fill_in[i] = '0;
                        head_in[i] = '0;
                     end
                  end
               end
            end else if (cur_last) begin
               cur_in   = '0;
               found_in = 1'b0;
            end else begin
               cur_in = cur_ff + LIST_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::ST_IDLE;
         remaining_ff <= '0;
         cur_ff       <= '0;
         found_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         cur_ff       <= cur_in;
         found_ff     <= found_in;
         overflow_ff  <= overflow_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      least_ff <= least_in;
   end

`ifndef SYNTHESIS
   a_rem_cap: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= TOT_W'(CAP))
      else $error("element count beyond store capacity");

   a_emit_dec: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_ready |=> remaining_ff == $past(remaining_ff) - TOT_W'(1))
      else $error("emitted beat did not retire one element");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_ready && emit_data.last |=>
         state_ff == kwm_pkg::ST_IDLE && remaining_ff == '0)
      else $error("merge did not finish after final beat");

   a_find_sets: assert property (@(posedge clock) disable iff (reset)
      state_ff == kwm_pkg::ST_FIND_CMP |=> found_ff)
      else $error("head compare left no least value");

   a_pop_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == kwm_pkg::ST_POP_CMP |-> found_ff)
      else $error("pop scan without a least value");
`endif

endmodule

@@ test/kwm_merge_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard of the k-way sorted merge block: predicts the merged beats from the request
// channel and compares every result beat. Depends on kwm_pkg and kwm_if.

module kwm_merge_checker #(
   parameter int NUM_LISTS  = 8,
   parameter int LIST_DEPTH = 8
) (
   input  logic   clock,
   input  logic   reset,
   kwm_req_if     req,
   kwm_rsp_if     rsp,
   output int     fail_count,
   output int     pending,
   output int     results_seen,
   output int     merges_seen
);

   // Shadow copy of the lists and the sticky drop flag
   logic signed [kwm_pkg::VALUE_W-1:0] list_store [NUM_LISTS][LIST_DEPTH];
   int                                 list_fill  [NUM_LISTS];
   bit                                 overflow_flag;

   kwm_pkg::kwm_result_type            merged_q [$];
   kwm_pkg::kwm_result_type            want;

   // Walk the lists round by round and queue one beat per element; hold back the
   // newest beat so that last can be set on the final one.
   task automatic predict_merge();
      int                                 head [NUM_LISTS];
      logic signed [kwm_pkg::VALUE_W-1:0] least;
      bit                                 found;
      bit                                 held;
      kwm_pkg::kwm_result_type            prev;
      held = 1'b0;
      least = '0;
      prev = '0;
      foreach (head[i]) head[i] = 0;
      do begin
         found = 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            if (head[i] < list_fill[i] && (!found || list_store[i][head[i]] < least)) begin
               least = list_store[i][head[i]];
               found = 1'b1;
            end
         end
         if (found) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               while (head[i] < list_fill[i] && list_store[i][head[i]] == least) begin
                  if (held) merged_q.push_back(prev);
                  prev.merged_value = list_store[i][head[i]];
                  prev.source_list  = kwm_pkg::SOURCE_W'(i);
                  prev.last         = 1'b0;
                  prev.dropped_any  = overflow_flag;
                  held = 1'b1;
                  head[i]++;
               end
            end
         end
      end while (found);
      if (held) begin
         prev.last = 1'b1;
         merged_q.push_back(prev);
      end
      foreach (list_fill[i]) list_fill[i] = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         merged_q.delete();
         foreach (list_fill[i]) list_fill[i] = 0;
         overflow_flag = 1'b0;
         pending <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (merged_q.size() == 0) begin
               $error("unexpected result beat: merged_value %0d source_list %0d",
                      rsp.merged_value, rsp.source_list);
               fail_count++;
            end else begin
               want = merged_q.pop_front();
               if (rsp.merged_value !== want.merged_value) begin
                  $error("merged_value: expected %0d, got %0d",
                         want.merged_value, rsp.merged_value);
                  fail_count++;
               end
               if (rsp.source_list !== want.source_list) begin
                  $error("source_list: expected %0d, got %0d",
                         want.source_list, rsp.source_list);
                  fail_count++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp.last);
                  fail_count++;
               end
               if (rsp.dropped_any !== want.dropped_any) begin
                  $error("dropped_any: expected %0b, got %0b",
                         want.dropped_any, rsp.dropped_any);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.kind == kwm_pkg::KIND_MERGE) begin
               merges_seen++;
               predict_merge();
            end else if (int'(req.list_index) < NUM_LISTS) begin
               if (list_fill[req.list_index] >= LIST_DEPTH) begin
                  overflow_flag = 1'b1;
               end else begin
                  list_store[req.list_index][list_fill[req.list_index]] = req.value;
                  list_fill[req.list_index]++;
               end
            end
         end
         pending <= merged_q.size();
      end
   end

endmodule

@@ test/k_way_sorted_merge_tb.sv @@
`timescale 1ns / 1ps
// Top of the k-way sorted merge testbench: clock, reset, request and result stimulus, verdict.
// Depends on kwm_pkg, kwm_if, the k_way_sorted_merge block and kwm_merge_checker.

module k_way_sorted_merge_tb;

   localparam int NUM_LISTS   = 8;
   localparam int LIST_DEPTH  = 8;
   localparam int RANDOM_BEATS = 250;

   logic clock;
   logic reset;

   kwm_req_if req_ch ();
   kwm_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int results_seen;
   int merges_seen;

   int beats_sent;
   int rsp_hold;
   bit no_gaps;          // set for stretches in which neither side idles
   int tail [NUM_LISTS]; // last value loaded per list when building sorted lists

   k_way_sorted_merge #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   kwm_merge_checker #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .merges_seen  (merges_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Value for a load: full range, a narrow band that breeds equal heads, or ascending per list
   function automatic logic signed [kwm_pkg::VALUE_W-1:0] pick_value(input int style,
                                                                     input int idx);
      int v;
      case (style)
         0: v = $urandom_range(0, 65535);
         1: v = int'($urandom_range(0, 6)) - 3;
         default: begin
            v = tail[idx] + int'($urandom_range(0, 4000));
            if (v > 32767) v = 32767;
            tail[idx] = v;
         end
      endcase
      return v[kwm_pkg::VALUE_W-1:0];
   endfunction

   // Present one beat, after an optional gap, and hold it until accepted.
   // Valid stays high on return so back-to-back beats need no second assignment.
   task automatic send_beat(input logic kind, input logic [kwm_pkg::INDEX_W-1:0] idx,
                            input logic signed [kwm_pkg::VALUE_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.kind       <= 1'($urandom_range(0, 1));
         req_ch.list_index <= kwm_pkg::INDEX_W'($urandom_range(0, 7));
         req_ch.value      <= kwm_pkg::VALUE_W'($urandom_range(0, 65535));
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.list_index <= idx;
      req_ch.value      <= val;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   // Merge beat with junk in the fields the block must ignore
   task automatic send_merge();
      send_beat(kwm_pkg::KIND_MERGE, kwm_pkg::INDEX_W'($urandom_range(0, 7)),
                kwm_pkg::VALUE_W'($urandom_range(0, 65535)));
   endtask

   // Drop valid and hold off until every predicted beat has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Result side: accept freely, stall briefly, or stall long now and then
   initial begin
      rsp_ch.ready <= 1'b0;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else if (no_gaps || $urandom_range(0, 99) < 70) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
         end
      end
   end

   initial begin
      int n_loads;
      int style;
      int idx;
      int guard;
      beats_sent = 0;
      no_gaps = 1'b0;
      foreach (tail[i]) tail[i] = -32768;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= kwm_pkg::KIND_LOAD;
      req_ch.list_index <= '0;
      req_ch.value      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Merge with nothing stored: no beat may come out
      send_merge();

      // Extremes, equal heads within a list and across lists, heads not in order
      send_beat(kwm_pkg::KIND_LOAD, 3'd0, 16'sh8000);
      send_beat(kwm_pkg::KIND_LOAD, 3'd7, 16'sh7fff);
      send_beat(kwm_pkg::KIND_LOAD, 3'd3, 16'sh0000);
      send_beat(kwm_pkg::KIND_LOAD, 3'd3, 16'sh0000);
      send_beat(kwm_pkg::KIND_LOAD, 3'd5, 16'sh0000);
      send_beat(kwm_pkg::KIND_LOAD, 3'd1, 16'shffff);
      send_beat(kwm_pkg::KIND_LOAD, 3'd1, 16'sh8000);
      send_merge();
      drain();

      // Overfill one list: the ninth load is dropped and the sticky flag rises
      for (int k = 0; k < LIST_DEPTH + 1; k++) begin
         send_beat(kwm_pkg::KIND_LOAD, 3'd2, kwm_pkg::VALUE_W'(k + 5));
      end
      send_merge();
      drain();

      // Random batches of loads, each closed by a merge
      while (beats_sent < RANDOM_BEATS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         style   = $urandom_range(0, 2);
         n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 16);
         foreach (tail[i]) tail[i] = ($urandom_range(0, 3) == 0) ? -32768 :
                                     int'($urandom_range(0, 30000)) - 32768;
         for (int k = 0; k < n_loads; k++) begin
            idx = $urandom_range(0, NUM_LISTS - 1);
            send_beat(kwm_pkg::KIND_LOAD, idx[kwm_pkg::INDEX_W-1:0], pick_value(style, idx));
         end
         send_merge();
         if ($urandom_range(0, 9) == 0) send_merge();
         if ($urandom_range(0, 5) == 0) drain();
      end
      no_gaps = 1'b0;
      req_ch.valid <= 1'b0;

      // Wait for the last beats, then allow for a trailing empty merge scan
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending != 0 && guard < 200000);
      repeat (300) @(posedge clock);

      $display("Sent %0d request beats including %0d merges; checked %0d result beats.",
               beats_sent, merges_seen, results_seen);
      $display("Mismatches and stray beats: %0d, beats still owed: %0d.", fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ k_way_sorted_merge.f @@
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kwm_store.sv
hw/rtl/kwm_seq.sv
hw/rtl/k_way_sorted_merge.sv
test/kwm_merge_checker.sv
test/k_way_sorted_merge_tb.sv
